[hdl/mtrr_pkg.sv]
// Shared types and constants for the MTRR memory-type lookup block.
`default_nettype none
package mtrr_pkg;

  localparam int unsigned VarRanges  = 32;
  localparam int unsigned RangeIdxW  = (VarRanges > 1) ? $clog2(VarRanges) : 1;
  localparam int unsigned AddrW      = 52;
  localparam int unsigned LenW       = AddrW + 1;
  localparam int unsigned WordW      = 64;
  localparam int unsigned SlotW      = 5;
  localparam int unsigned PhysBitsW  = 6;
  localparam int unsigned FixedWords = 11;
  localparam int unsigned FixedIdxW  = 4;

  localparam logic [PhysBitsW-1:0] PhysBitsReset = PhysBitsW'(36);
  localparam logic [PhysBitsW-1:0] PhysBitsMax   = PhysBitsW'(52);
  localparam logic [AddrW-1:0]     FixedLimit    = AddrW'(64'h100000);
  localparam logic [AddrW-1:0]     PageMask      = AddrW'(64'hFFF);
  localparam logic [7:0]           TypeWriteback = 8'd6;
  localparam int unsigned          ValidBit      = 11;

  typedef enum logic [1:0] {
    OpLookup    = 2'd0,
    OpLoadFixed = 2'd1,
    OpLoadVar   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    SrcFixed   = 2'd0,
    SrcVar     = 2'd1,
    SrcDefault = 2'd2
  } src_e;

  typedef struct packed {
    logic [AddrW-1:0] base;
    logic [LenW-1:0]  length;
    logic [7:0]       mtype;
  } range_ent_t;

  typedef struct packed {
    logic                 we;
    logic [RangeIdxW-1:0] addr;
    logic                 valid;
    range_ent_t           ent;
  } range_wr_t;

endpackage
`default_nettype wire

[hdl/mtrr_if.sv]
// Handshake channels of the MTRR lookup block: request, response and configuration.
`default_nettype none
interface mtrr_req_if;
  import mtrr_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       op;
  logic [AddrW-1:0] address;
  logic [SlotW-1:0] slot;
  logic [WordW-1:0] fixed_word;
  logic [WordW-1:0] base_word;
  logic [WordW-1:0] mask_word;
  modport source (output valid, op, address, slot, fixed_word, base_word, mask_word,
                  input ready);
  modport sink (input valid, op, address, slot, fixed_word, base_word, mask_word,
                output ready);
endinterface

interface mtrr_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] mem_type;
  logic [1:0] src;
  modport source (output valid, mem_type, src, input ready);
  modport sink (input valid, mem_type, src, output ready);
endinterface

interface mtrr_cfg_if;
  import mtrr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [PhysBitsW-1:0] phys_bits;
  modport source (output valid, phys_bits, input ready);
  modport sink (input valid, phys_bits, output ready);
endinterface
`default_nettype wire

[hdl/mtrr_fixed_regs.sv]
// Fixed-range type words and the decode of a sub-1MiB address to its type byte.
`default_nettype none
module mtrr_fixed_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           we_i,
  input  logic [mtrr_pkg::FixedIdxW-1:0] widx_i,
  input  logic [mtrr_pkg::WordW-1:0]     wdata_i,
  input  logic [19:0]                    addr_i,
  output logic [7:0]                     mem_type_o
);
  import mtrr_pkg::*;

  logic [WordW-1:0]     words_q [FixedWords];
  logic [FixedIdxW-1:0] sel_word;
  logic [2:0]           sel_byte;
  logic [WordW-1:0]     word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FixedWords; i++) begin
        words_q[i] <= '0;
      end
    end else if (we_i) begin
      words_q[widx_i] <= wdata_i;
    end
  end

  // The 64K region uses one word, the two 16K regions one each, and the
  // 4K region spreads over the remaining eight words.
  always_comb begin
    if (!addr_i[19]) begin
      sel_word = FixedIdxW'(0);
      sel_byte = addr_i[18:16];
    end else if (!addr_i[18] && !addr_i[17]) begin
      sel_word = FixedIdxW'(1);
      sel_byte = addr_i[16:14];
    end else if (!addr_i[18]) begin
      sel_word = FixedIdxW'(2);
      sel_byte = addr_i[16:14];
    end else begin
      sel_word = FixedIdxW'(addr_i[17:15]) + FixedIdxW'(3);
      sel_byte = addr_i[14:12];
    end
  end

  assign word       = words_q[sel_word];
  assign mem_type_o = word[{sel_byte, 3'b000} +: 8];

endmodule
`default_nettype wire

[hdl/mtrr_range_ram.sv]
// Variable-range storage: entry memory with a registered read, plus reset-cleared valid bits.
`default_nettype none
module mtrr_range_ram (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mtrr_pkg::range_wr_t            wr_i,
  input  logic [mtrr_pkg::RangeIdxW-1:0] raddr_i,
  output mtrr_pkg::range_ent_t           rdata_o,
  output logic                           rvalid_o
);
  import mtrr_pkg::*;

  range_ent_t           mem [VarRanges];
  logic [VarRanges-1:0] valid_q;
  range_ent_t           rdata_q;
  logic                 rvalid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.ent;
    end
    rdata_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (wr_i.we) begin
        valid_q[wr_i.addr] <= wr_i.valid;
      end
      rvalid_q <= valid_q[raddr_i];
    end
  end

  assign rdata_o  = rdata_q;
  assign rvalid_o = rvalid_q;

endmodule
`default_nettype wire

[hdl/mtrr_range_cmp.sv]
// Shared range comparator: tests whether an address falls inside one variable range.
`default_nettype none
module mtrr_range_cmp (
  input  mtrr_pkg::range_ent_t       ent_i,
  input  logic                       valid_i,
  input  logic [mtrr_pkg::AddrW-1:0] addr_i,
  output logic                       hit_o
);
  import mtrr_pkg::*;

  logic [LenW-1:0] limit;

  assign limit = LenW'(ent_i.base) + ent_i.length;
  assign hit_o = valid_i && (ent_i.base <= addr_i) && (limit > LenW'(addr_i));

endmodule
`default_nettype wire

[hdl/mtrr_memory_type_lookup.sv]
// Top level of the MTRR memory-type lookup: request decode, range scan sequencer and output.
//
// Requests arrive on req_i. A fixed-word load or a variable-range load is
// taken while idle and produces no response. A lookup below 1 MiB
// reads the fixed-range words in StFixed and answers via StDone.
// A lookup at or above 1 MiB walks the variable ranges one per cycle
// through a single comparator, stopping at the first hit, a rate bounded
// by the one read port of the range memory. req_i.ready is high only
// while no lookup is in progress. Results leave through an output
// register on rsp_o; if the receiver stalls, a finished result waits in
// the sequencer and no new request is taken until the output register
// frees up.
// cfg_i writes the physical address width; it is always ready and is
// meant to be written while the block is idle. Reset clears all fixed
// words and range valid bits, sets the width to 36 and leaves the
// block idle with no response pending.
`default_nettype none
module mtrr_memory_type_lookup (
  input  logic              clk_i,
  input  logic              rst_ni,
  mtrr_cfg_if.sink          cfg_i,
  mtrr_req_if.sink          req_i,
  mtrr_rsp_if.source        rsp_o
);
  import mtrr_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StFixed,
    StScan,
    StDone
  } state_e;

  state_e               state_q, state_d;
  logic [RangeIdxW-1:0] idx_q, idx_d;
  logic [AddrW-1:0]     addr_q, addr_d;
  logic [7:0]           res_type_q, res_type_d;
  src_e                 res_src_q, res_src_d;
  logic                 out_valid_q, out_valid_d;
  logic [7:0]           out_type_q, out_type_d;
  src_e                 out_src_q, out_src_d;
  logic [PhysBitsW-1:0] phys_bits_q;

  logic                 req_fire;
  logic [PhysBitsW-1:0] bits_clamped;
  logic [AddrW-1:0]     phys_mask;
  logic [AddrW-1:0]     field_mask;
  range_wr_t            range_wr;
  logic [RangeIdxW-1:0] raddr;
  range_ent_t           rd_ent;
  logic                 rd_valid;
  logic                 hit;
  logic                 fixed_we;
  logic [7:0]           fixed_type;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phys_bits_q <= PhysBitsReset;
    end else if (cfg_i.valid) begin
      phys_bits_q <= cfg_i.phys_bits;
    end
  end

  assign req_i.ready = (state_q == StIdle);
  assign req_fire    = req_i.valid && (state_q == StIdle);

  // Physical mask with the width clamped to 1..52 bits.
  always_comb begin
    if (phys_bits_q == '0) begin
      bits_clamped = PhysBitsW'(1);
    end else if (phys_bits_q > PhysBitsMax) begin
      bits_clamped = PhysBitsMax;
    end else begin
      bits_clamped = phys_bits_q;
    end
  end

  assign phys_mask  = ~({AddrW{1'b1}} << bits_clamped);
  assign field_mask = phys_mask & ~PageMask;

  always_comb begin
    range_wr.we         = req_fire && (op_e'(req_i.op) == OpLoadVar)
                          && (32'(req_i.slot) < VarRanges);
    range_wr.addr       = RangeIdxW'(req_i.slot);
    range_wr.valid      = req_i.mask_word[ValidBit];
    range_wr.ent.base   = req_i.base_word[AddrW-1:0] & field_mask;
    range_wr.ent.length = LenW'(~(req_i.mask_word[AddrW-1:0] & field_mask) & phys_mask)
                          + LenW'(1);
    range_wr.ent.mtype  = req_i.base_word[7:0];
  end

  assign fixed_we = req_fire && (op_e'(req_i.op) == OpLoadFixed)
                    && (32'(req_i.slot) < FixedWords);

  // While scanning, fetch the entry after the one being compared.
  assign raddr = (state_q == StScan) ? idx_q + RangeIdxW'(1) : '0;

  mtrr_fixed_regs u_fixed (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .we_i       (fixed_we),
    .widx_i     (FixedIdxW'(req_i.slot)),
    .wdata_i    (req_i.fixed_word),
    .addr_i     (addr_q[19:0]),
    .mem_type_o (fixed_type)
  );

  mtrr_range_ram u_ram (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (range_wr),
    .raddr_i  (raddr),
    .rdata_o  (rd_ent),
    .rvalid_o (rd_valid)
  );

  mtrr_range_cmp u_cmp (
    .ent_i   (rd_ent),
    .valid_i (rd_valid),
    .addr_i  (addr_q),
    .hit_o   (hit)
  );

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    addr_d      = addr_q;
    res_type_d  = res_type_q;
    res_src_d   = res_src_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_type_d  = out_type_q;
    out_src_d   = out_src_q;

    case (state_q)
      StIdle: begin
        if (req_fire && (op_e'(req_i.op) == OpLookup)) begin
          addr_d = req_i.address;
          idx_d  = '0;
          state_d = (req_i.address < FixedLimit) ? StFixed : StScan;
        end
      end
      StFixed: begin
        res_type_d = fixed_type;
        res_src_d  = SrcFixed;
        state_d    = StDone;
      end
      StScan: begin
        if (hit) begin
          res_type_d = rd_ent.mtype;
          res_src_d  = SrcVar;
          state_d    = StDone;
        end else if (idx_q == RangeIdxW'(VarRanges - 1)) begin
          res_type_d = TypeWriteback;
          res_src_d  = SrcDefault;
          state_d    = StDone;
        end else begin
          idx_d = idx_q + RangeIdxW'(1);
        end
      end
      StDone: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_type_d  = res_type_q;
          out_src_d   = res_src_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= '0;
      addr_q      <= '0;
      res_type_q  <= '0;
      res_src_q   <= SrcDefault;
      out_valid_q <= 1'b0;
      out_type_q  <= '0;
      out_src_q   <= SrcDefault;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      addr_q      <= addr_d;
      res_type_q  <= res_type_d;
      res_src_q   <= res_src_d;
      out_valid_q <= out_valid_d;
      out_type_q  <= out_type_d;
      out_src_q   <= out_src_d;
    end
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.mem_type = out_type_q;
  assign rsp_o.src      = out_src_q;

endmodule
`default_nettype wire
